// ===== src/smfbs_pkg.sv =====
// ----------------------------------------------------------------------------
// smfbs_pkg
// Types and fixed constants shared by the sorted matrix search block.
// ----------------------------------------------------------------------------
package smfbs_pkg;

	// Fixed field widths
	localparam int DATA_W = 32;
	localparam int IDX_W  = 5;
	localparam int SIDE_W = 6;

	// Side register value after reset
	localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

	// Item modes
	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SEARCH = 1'b1;

	// Input item
	typedef struct packed {
		logic                     mode;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         column_index;
		logic signed [DATA_W-1:0] data_value;
	} smfbs_in_t;

	// Result item
	typedef struct packed {
		logic                     found;
		logic signed [DATA_W-1:0] match_value;
		logic [IDX_W-1:0]         match_row;
		logic [IDX_W-1:0]         match_column;
	} smfbs_out_t;

endpackage

// ===== src/sorted_matrix_flat_binary_search.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_flat_binary_search
// Square matrix store with bisection search over the flattened index range.
// ----------------------------------------------------------------------------
// A write item stores one signed word at (row, column) and gives no result;
// writes with row or column at SIDE_MAX or above are dropped. A search item
// bisects the flat range 0 .. side*side-1 and gives one result: the first
// probe that matches is reported, so among duplicates the bisection order
// decides which one. Each probe steps through midpoint, the restoring
// divider that turns the midpoint into row and column at one quotient bit
// per cycle and then raises its finish flag, memory read and compare. A
// search makes at most ceil(log2(side*side + 1)) probes, 11 for a side of
// 32. The block takes no item while a search runs or while its result waits.
// The store is not cleared: searching entries never written is not allowed.
// A side register of zero acts as 1, above SIDE_MAX as SIDE_MAX.
// ----------------------------------------------------------------------------
module sorted_matrix_flat_binary_search import smfbs_pkg::*; #(
	parameter int SIDE_MAX = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIDE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  smfbs_in_t         in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output smfbs_out_t        out_item
);

	localparam int RW    = (SIDE_MAX > 1) ? $clog2(SIDE_MAX) : 1;
	localparam int SW    = RW + 1;
	localparam int FW    = 2 * RW;
	localparam int DEPTH = SIDE_MAX * SIDE_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MID  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_READ = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]               state_q;
	logic [SIDE_W-1:0]        side_q;
	logic [SW-1:0]            side_eff;
	logic [SW-1:0]            sd_q;
	logic [FW:0]              lo_q;
	logic [FW:0]              hie_q;
	logic [FW-1:0]            mid_q;
	logic [FW+1:0]            mid_sum;
	logic [FW-1:0]            mid;
	logic signed [DATA_W-1:0] key_q;
	smfbs_out_t               res_q;
	smfbs_out_t               out_q;
	logic                     out_valid_q;
	logic                     in_acc;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	logic                     div_start;
	logic                     div_done;
	logic [RW-1:0]            quo;
	logic [RW-1:0]            rem;
	logic                     out_load;

	// Side register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			side_q <= cfg_data;
		end
	end

	// Clamp the side into 1 .. SIDE_MAX
	always_comb begin
		if (int'(side_q) > SIDE_MAX) begin
			side_eff = SW'(SIDE_MAX);
		end else if (side_q == '0) begin
			side_eff = SW'(1);
		end else begin
			side_eff = SW'(side_q);
		end
	end

	// Input handshake and write port
	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign wr_en    = in_acc && (in_item.mode == MODE_WRITE) &&
	                  (int'(in_item.row_index) < SIDE_MAX) &&
	                  (int'(in_item.column_index) < SIDE_MAX);
	assign wr_addr  = AW'(in_item.row_index) * AW'(SIDE_MAX) + AW'(in_item.column_index);

	// Midpoint of the live range
	assign mid_sum = (FW+2)'(lo_q) + (FW+2)'(hie_q) - (FW+2)'(1);
	assign mid     = FW'(mid_sum >> 1);

	assign div_start = (state_q == S_MID) && (lo_q < hie_q);
	assign rd_en     = (state_q == S_READ);
	assign rd_addr   = AW'(quo) * AW'(SIDE_MAX) + AW'(rem);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && (in_item.mode == MODE_SEARCH)) begin
						state_q <= S_MID;
					end
				end
				S_MID: begin
					state_q <= (lo_q < hie_q) ? S_DIV : S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= (rd_data == key_q) ? S_DONE : S_MID;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Search range, key and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					sd_q  <= side_eff;
					lo_q  <= '0;
					hie_q <= (FW+1)'(side_eff) * (FW+1)'(side_eff);
					key_q <= in_item.data_value;
					res_q <= '0;
				end
			end
			S_MID: begin
				mid_q <= mid;
			end
			S_CMP: begin
				if (rd_data == key_q) begin
					res_q.found        <= 1'b1;
					res_q.match_value  <= rd_data;
					res_q.match_row    <= IDX_W'(quo);
					res_q.match_column <= IDX_W'(rem);
				end else if (key_q < rd_data) begin
					hie_q <= (FW+1)'(mid_q);
				end else begin
					lo_q <= (FW+1)'(mid_q) + (FW+1)'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Row and column of the midpoint
	smfbs_div #(
		.FW(FW),
		.QW(RW),
		.SW(SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mid),
		.divisor  (sd_q),
		.done     (div_done),
		.quotient (quo),
		.remainder(rem)
	);

	// Matrix words
	smfbs_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(in_item.data_value),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// The live range never inverts
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MID) |-> (lo_q <= hie_q))
		else $error("search range inverted");

	// A compare always follows a fresh read
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ($past(state_q) == S_READ))
		else $error("compare without a read");

	// Row and column lie inside the side in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> ((SW'(quo) < sd_q) && (SW'(rem) < sd_q)))
		else $error("divider result out of range");

endmodule

// ===== src/smfbs_store.sv =====
// ----------------------------------------------------------------------------
// smfbs_store
// Matrix word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module smfbs_store import smfbs_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic signed [DATA_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic signed [DATA_W-1:0] rd_data
);

	logic signed [DATA_W-1:0] mem_q [DEPTH];
	logic signed [DATA_W-1:0] rd_data_q;

	// Store one word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Fetch one word, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/smfbs_div.sv =====
// ----------------------------------------------------------------------------
// smfbs_div
// Restoring divider: splits a flat index into row and column, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module smfbs_div #(
	parameter int FW = 10,
	parameter int QW = 5,
	parameter int SW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [FW-1:0] dividend,
	input  logic [SW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quotient,
	output logic [QW-1:0] remainder
);

	localparam int CW = $clog2(QW + 1);

	logic [FW-1:0] rem_q;
	logic [FW:0]   dvs_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic          ge;

	// Trial subtraction of the shifted divisor
	assign ge = ({1'b0, rem_q} >= dvs_q);

	// Step counter and finish flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(QW);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder, divisor and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dvs_q <= (FW+1)'(divisor) << (QW - 1);
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - FW'(dvs_q);
			end
			quo_q <= QW'({quo_q, ge});
			dvs_q <= dvs_q >> 1;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = QW'(rem_q);

endmodule
